### design/fsc_pkg.sv
package fsc_pkg;

  // frustum size and register map
  localparam int unsigned NumPlanes = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PLANE_0   = 3'd0,
    REG_PLANE_1   = 3'd1,
    REG_PLANE_2   = 3'd2,
    REG_PLANE_3   = 3'd3,
    REG_PLANE_4   = 3'd4,
    REG_PLANE_5   = 3'd5,
    REG_CULL_MODE = 3'd6,
    REG_UNUSED    = 3'd7
  } cfg_reg_e;

  // cull_mode bits
  localparam int unsigned ModeRefl      = 0;
  localparam int unsigned ModeRstHidden = 1;
  localparam int unsigned ModeMarkers   = 2;
  localparam int unsigned ModeW         = 3;

  // object_flags bits
  localparam int unsigned FlForce    = 0;
  localparam int unsigned FlDrawable = 1;
  localparam int unsigned FlMirror   = 2;
  localparam int unsigned FlHidden   = 3;
  localparam int unsigned FlEffHid   = 4;
  localparam int unsigned FlShrouded = 5;
  localparam int unsigned FlTransl   = 6;
  localparam int unsigned FlStruct   = 7;
  localparam int unsigned FlOccludee = 8;
  localparam int unsigned FlagsW     = 9;

  // fixed-point widths
  localparam int unsigned PosW   = 24;
  localparam int unsigned NormW  = 12;
  localparam int unsigned DistW  = 28;
  localparam int unsigned ProdW  = PosW + NormW;
  localparam int unsigned DotW   = ProdW + 2;
  localparam int unsigned BoundW = DistW + 1;
  localparam int unsigned FracSh = 10;
  localparam int unsigned CmpW   = BoundW + FracSh + 1;

  // plane register layout, msb first
  typedef struct packed {
    logic signed [DistW-1:0] distance;
    logic signed [NormW-1:0] nz;
    logic signed [NormW-1:0] ny;
    logic signed [NormW-1:0] nx;
  } plane_t;

  // one input beat
  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic [PosW-1:0]        bound_radius;
    logic [FlagsW-1:0]      object_flags;
    logic                   last_object;
  } obj_t;

  // one result beat
  typedef struct packed {
    logic is_visible;
    logic needs_draw_flag_reset;
    logic mark_translucent;
    logic mark_occluder;
    logic mark_occludee;
    logic frame_done;
  } res_t;

  // sideband that travels beside the plane tests
  typedef struct packed {
    logic              valid;
    logic [FlagsW-1:0] flags;
    logic              last;
  } side_t;

endpackage

### design/fsc_plane_test.sv
module fsc_plane_test (
  input  logic                              clk_i,
  input  fsc_pkg::plane_t                   plane_i,
  input  logic signed [fsc_pkg::PosW-1:0]   pos_x_i,
  input  logic signed [fsc_pkg::PosW-1:0]   pos_y_i,
  input  logic signed [fsc_pkg::PosW-1:0]   pos_z_i,
  input  logic [fsc_pkg::PosW-1:0]          radius_i,
  output logic                              outside_o
);

  // stage 1: three products
  logic signed [fsc_pkg::ProdW-1:0] px_d, py_d, pz_d;
  logic signed [fsc_pkg::ProdW-1:0] px_q, py_q, pz_q;
  logic [fsc_pkg::PosW-1:0]         rad_q;

  assign px_d = pos_x_i * plane_i.nx;
  assign py_d = pos_y_i * plane_i.ny;
  assign pz_d = pos_z_i * plane_i.nz;

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    pz_q  <= pz_d;
    rad_q <= radius_i;
  end

  // stage 2: dot product and radius plus distance
  logic signed [fsc_pkg::DotW-1:0]   dot_d, dot_q;
  logic signed [fsc_pkg::BoundW-1:0] bound_d, bound_q;

  assign dot_d = fsc_pkg::DotW'(px_q) + fsc_pkg::DotW'(py_q) + fsc_pkg::DotW'(pz_q);
  assign bound_d = $signed({{(fsc_pkg::BoundW-fsc_pkg::PosW){1'b0}}, rad_q})
                 + $signed({plane_i.distance[fsc_pkg::DistW-1], plane_i.distance});

  always_ff @(posedge clk_i) begin
    dot_q   <= dot_d;
    bound_q <= bound_d;
  end

  // stage 3: dot - dist*1024 > radius*1024
  logic signed [fsc_pkg::CmpW-1:0] lhs, rhs;
  logic                            outside_d, outside_q;

  assign lhs = fsc_pkg::CmpW'(dot_q);
  assign rhs = $signed({bound_q[fsc_pkg::BoundW-1], bound_q, {fsc_pkg::FracSh{1'b0}}});
  assign outside_d = lhs > rhs;

  always_ff @(posedge clk_i) begin
    outside_q <= outside_d;
  end

  assign outside_o = outside_q;

endmodule

### design/fsc_classify.sv
module fsc_classify (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fsc_pkg::side_t                  side_i,
  input  logic [fsc_pkg::NumPlanes-1:0]   outside_i,
  input  logic [fsc_pkg::ModeW-1:0]       cull_mode_i,
  output logic                            res_valid_o,
  output fsc_pkg::res_t                   res_o
);

  logic       in_frustum;
  logic       refl, rst_hidden, markers;
  logic [fsc_pkg::FlagsW-1:0] f;
  fsc_pkg::res_t res_d, res_q;
  logic       valid_q;

  assign in_frustum = ~|outside_i;
  assign f          = side_i.flags;
  assign refl       = cull_mode_i[fsc_pkg::ModeRefl];
  assign rst_hidden = cull_mode_i[fsc_pkg::ModeRstHidden];
  assign markers    = cull_mode_i[fsc_pkg::ModeMarkers];

  // classification rules in priority order
  always_comb begin
    res_d = '0;
    res_d.frame_done = side_i.last;
    priority if (f[fsc_pkg::FlForce]) begin
      res_d.is_visible = 1'b1;
    end else if (refl) begin
      res_d.is_visible = in_frustum &&
                         (!f[fsc_pkg::FlDrawable] || f[fsc_pkg::FlMirror]);
    end else if (!f[fsc_pkg::FlHidden] && in_frustum) begin
      if (!f[fsc_pkg::FlDrawable]) begin
        res_d.is_visible = 1'b1;
      end else if (f[fsc_pkg::FlEffHid] || f[fsc_pkg::FlShrouded]) begin
        res_d.needs_draw_flag_reset = rst_hidden;
      end else begin
        res_d.is_visible            = 1'b1;
        res_d.needs_draw_flag_reset = 1'b1;
        res_d.mark_translucent      = f[fsc_pkg::FlTransl];
        res_d.mark_occluder         = markers && f[fsc_pkg::FlStruct];
        res_d.mark_occludee         = markers && f[fsc_pkg::FlOccludee];
      end
    end else begin
      // hidden or culled: every mark stays clear
      res_d.is_visible = 1'b0;
    end
  end

  // output register: one beat per strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= side_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### design/frustum_sphere_cull_classifier.sv
// Frustum sphere cull classifier. Takes one object per clock on start_i and
// returns its classification on result_o with res_valid_o high for exactly one
// cycle, once the object has passed the pipeline registers below, in input
// order. busy_o never rises: the six plane tests run side by side as a fixed
// pipeline (products, dot sum, compare, classify), 18 multipliers of 24 by 12
// bits, with no backpressure, so results must be captured when strobed. Plane
// and cull_mode registers are written through cfg_we_i / cfg_idx_i / cfg_data_i
// and are read live by the pipeline, so write them only while no object is in
// flight.
module frustum_sphere_cull_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  fsc_pkg::obj_t                  obj_i,
  input  logic                           cfg_we_i,
  input  logic [fsc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fsc_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                           res_valid_o,
  output fsc_pkg::res_t                  result_o
);

  localparam int unsigned SideStages = 3;

  // configuration registers
  fsc_pkg::plane_t               plane_q [fsc_pkg::NumPlanes];
  logic [fsc_pkg::ModeW-1:0]     mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fsc_pkg::NumPlanes; i++) begin
        plane_q[i] <= '0;
      end
      mode_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fsc_pkg::REG_CULL_MODE) begin
        mode_q <= cfg_data_i[fsc_pkg::ModeW-1:0];
      end
      for (int i = 0; i < fsc_pkg::NumPlanes; i++) begin
        if (cfg_idx_i == fsc_pkg::CfgIdxW'(i)) begin
          plane_q[i] <= fsc_pkg::plane_t'(cfg_data_i);
        end
      end
    end
  end

  // never stalls
  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // plane tests, one lane per plane
  logic [fsc_pkg::NumPlanes-1:0] outside;

  for (genvar p = 0; p < fsc_pkg::NumPlanes; p++) begin : g_plane
    fsc_plane_test u_plane (
      .clk_i     (clk_i),
      .plane_i   (plane_q[p]),
      .pos_x_i   (obj_i.pos_x),
      .pos_y_i   (obj_i.pos_y),
      .pos_z_i   (obj_i.pos_z),
      .radius_i  (obj_i.bound_radius),
      .outside_o (outside[p])
    );
  end

  // sideband pipe aligned with the plane test stages
  fsc_pkg::side_t side_d;
  fsc_pkg::side_t side_q [SideStages];

  assign side_d.valid = accept;
  assign side_d.flags = obj_i.object_flags;
  assign side_d.last  = obj_i.last_object;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SideStages; s++) begin
        side_q[s] <= '0;
      end
    end else begin
      side_q[0] <= side_d;
      for (int s = 1; s < SideStages; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // classification and result register
  fsc_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .side_i      (side_q[SideStages-1]),
    .outside_i   (outside),
    .cull_mode_i (mode_q),
    .res_valid_o (res_valid_o),
    .res_o       (result_o)
  );

endmodule

### dv/tb_top.sv
module tb_top;
  import fsc_pkg::*;

  localparam int          UnitNorm    = 1 << FracSh;
  localparam int          NormMax     = (1 << (NormW - 1)) - 1;
  localparam int          NormMin     = -(1 << (NormW - 1));
  localparam int          DistMax     = (1 << (DistW - 1)) - 1;
  localparam int          DistMin     = -(1 << (DistW - 1));
  localparam int          PosMax      = (1 << (PosW - 1)) - 1;
  localparam int          PosMin      = -(1 << (PosW - 1));
  localparam int          RadMax      = (1 << PosW) - 1;
  localparam int unsigned RandItems   = 900;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 500_000;

  // flag masks for directed objects
  localparam logic [FlagsW-1:0] FForce  = FlagsW'(1 << FlForce);
  localparam logic [FlagsW-1:0] FDraw   = FlagsW'(1 << FlDrawable);
  localparam logic [FlagsW-1:0] FMirror = FlagsW'(1 << FlMirror);
  localparam logic [FlagsW-1:0] FHidden = FlagsW'(1 << FlHidden);
  localparam logic [FlagsW-1:0] FEffHid = FlagsW'(1 << FlEffHid);
  localparam logic [FlagsW-1:0] FShroud = FlagsW'(1 << FlShrouded);
  localparam logic [FlagsW-1:0] FTransl = FlagsW'(1 << FlTransl);
  localparam logic [FlagsW-1:0] FStruct = FlagsW'(1 << FlStruct);
  localparam logic [FlagsW-1:0] FOccl   = FlagsW'(1 << FlOccludee);

  // predicts the classification of each object and checks result beats in order
  class cull_scoreboard;
    plane_t           planes[NumPlanes];
    logic [ModeW-1:0] mode;
    res_t             expected_q[$];
    int unsigned      errors;
    int unsigned      objects;
    int unsigned      results;
    int unsigned      visible;

    function new();
      foreach (planes[i]) planes[i] = '0;
      mode = '0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      if (idx == REG_CULL_MODE) begin
        mode = data[ModeW-1:0];
      end else if (int'(idx) < NumPlanes) begin
        planes[idx] = plane_t'(data);
      end
    endfunction

    // exact Q.10 test of the sphere against all six planes
    function bit sphere_in_frustum(obj_t o);
      longint cx, cy, cz, rad, dot, pdist;
      cx  = longint'($signed(o.pos_x));
      cy  = longint'($signed(o.pos_y));
      cz  = longint'($signed(o.pos_z));
      rad = longint'(o.bound_radius);
      for (int i = 0; i < NumPlanes; i++) begin
        dot  = cx * longint'($signed(planes[i].nx)) + cy * longint'($signed(planes[i].ny)) +
               cz * longint'($signed(planes[i].nz));
        pdist = longint'($signed(planes[i].distance));
        if (dot - pdist * UnitNorm > rad * UnitNorm) return 1'b0;
      end
      return 1'b1;
    endfunction

    function res_t classify_object(obj_t o);
      res_t              r;
      logic [FlagsW-1:0] f;
      r = '0;
      f = o.object_flags;
      r.frame_done = o.last_object;
      if (f[FlForce]) begin
        r.is_visible = 1'b1;
      end else if (mode[ModeRefl]) begin
        // reflection pass keeps non-drawables and mirrors only
        if ((!f[FlDrawable] || f[FlMirror]) && sphere_in_frustum(o)) r.is_visible = 1'b1;
      end else if (!f[FlHidden] && sphere_in_frustum(o)) begin
        if (!f[FlDrawable]) begin
          r.is_visible = 1'b1;
        end else if (f[FlEffHid] || f[FlShrouded]) begin
          r.needs_draw_flag_reset = mode[ModeRstHidden];
        end else begin
          r.is_visible            = 1'b1;
          r.needs_draw_flag_reset = 1'b1;
          r.mark_translucent      = f[FlTransl];
          if (mode[ModeMarkers]) begin
            r.mark_occluder = f[FlStruct];
            r.mark_occludee = f[FlOccludee];
          end
        end
      end
      return r;
    endfunction

    function void note_object(obj_t o);
      res_t r;
      r = classify_object(o);
      expected_q.push_back(r);
      objects++;
      if (r.is_visible) visible++;
    endfunction

    function void cmp_field(string name, logic exp_v, logic act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0b, got %0b", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(res_t act);
      res_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result beat with no object outstanding");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      results++;
      cmp_field("is_visible", exp_r.is_visible, act.is_visible);
      cmp_field("needs_draw_flag_reset", exp_r.needs_draw_flag_reset,
                act.needs_draw_flag_reset);
      cmp_field("mark_translucent", exp_r.mark_translucent, act.mark_translucent);
      cmp_field("mark_occluder", exp_r.mark_occluder, act.mark_occluder);
      cmp_field("mark_occludee", exp_r.mark_occludee, act.mark_occludee);
      cmp_field("frame_done", exp_r.frame_done, act.frame_done);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni     = 1'b0;
  logic                 start_i    = 1'b0;
  logic                 busy_o;
  obj_t                 obj_i      = '0;
  logic                 cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i  = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 res_valid_o;
  res_t                 result_o;

  cull_scoreboard sb = new();
  plane_t         next_planes[NumPlanes];
  obj_t           batch[$];
  int unsigned    cycle_cnt = 0;
  int unsigned    settings  = 0;

  frustum_sphere_cull_classifier dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .obj_i      (obj_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_valid_o(res_valid_o),
    .result_o   (result_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result beats are captured on the strobe
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && res_valid_o === 1'b1) sb.check_result(result_o);
  end

  // run limit
  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic obj_t mk_obj(int x, int y, int z, int r, logic [FlagsW-1:0] f, bit last);
    obj_t o;
    o.pos_x        = PosW'(x);
    o.pos_y        = PosW'(y);
    o.pos_z        = PosW'(z);
    o.bound_radius = PosW'(r);
    o.object_flags = f;
    o.last_object  = last;
    return o;
  endfunction

  function automatic plane_t mk_plane(int nx, int ny, int nz, int d);
    plane_t pl;
    pl.nx       = NormW'(nx);
    pl.ny       = NormW'(ny);
    pl.nz       = NormW'(nz);
    pl.distance = DistW'(d);
    return pl;
  endfunction

  // axis-aligned box side: planes 0/1 on x, 2/3 on y, 4/5 on z, odd ones face negative
  function automatic plane_t box_plane(int p, int e);
    int n;
    n = (p % 2) ? -UnitNorm : UnitNorm;
    case (p / 2)
      0:       return mk_plane(n, 0, 0, e);
      1:       return mk_plane(0, n, 0, e);
      default: return mk_plane(0, 0, n, e);
    endcase
  endfunction

  // mostly box sides, some tilted, some open, a few raw
  function automatic plane_t rand_plane(int p, int k, int e);
    plane_t pl;
    int     sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      pl = box_plane(p, e);
    end else if (sel < 8) begin
      pl          = plane_t'({$urandom, $urandom});
      pl.distance = DistW'(int'($urandom_range(0, 5 << k)) - (1 << k));
    end else if (sel == 8) begin
      pl = mk_plane(0, 0, 0, $urandom_range(0, 1 << 26));
    end else begin
      pl = plane_t'({$urandom, $urandom});
    end
    return pl;
  endfunction

  function automatic logic [PosW-1:0] rand_coord(int k);
    int v;
    if ($urandom_range(0, 7) == 0) v = $urandom;
    else v = int'($urandom_range(0, 1 << (k + 2))) - (1 << (k + 1));
    return v[PosW-1:0];
  endfunction

  // most objects get plausible flags so the drawable rules are reached
  function automatic logic [FlagsW-1:0] rand_flags();
    logic [FlagsW-1:0] f;
    f = FlagsW'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      f[FlForce]    = ($urandom_range(0, 9) == 0);
      f[FlDrawable] = ($urandom_range(0, 3) != 0);
      f[FlHidden]   = ($urandom_range(0, 9) == 0);
      f[FlEffHid]   = ($urandom_range(0, 6) == 0);
      f[FlShrouded] = ($urandom_range(0, 6) == 0);
    end
    return f;
  endfunction

  function automatic obj_t rand_object(int k);
    obj_t o;
    o.pos_x = rand_coord(k);
    o.pos_y = rand_coord(k);
    o.pos_z = rand_coord(k);
    if ($urandom_range(0, 7) == 0) o.bound_radius = PosW'($urandom);
    else o.bound_radius = PosW'($urandom_range(0, (1 << k) / 4));
    o.object_flags = rand_flags();
    o.last_object  = ($urandom_range(0, 7) == 0);
    return o;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic put_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // write every register from next_planes and the given mode, junk in unused bits
  task automatic program_regs(input logic [ModeW-1:0] md);
    logic [CfgDataW-1:0] d;
    put_reg(REG_UNUSED, {$urandom, $urandom});
    for (int p = 0; p < NumPlanes; p++) put_reg(cfg_reg_e'(REG_PLANE_0 + p), next_planes[p]);
    d              = {$urandom, $urandom};
    d[ModeW-1:0]   = md;
    put_reg(REG_CULL_MODE, d);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // one object beat, start stays high when no gap follows
  task automatic send_obj(input obj_t o, input int unsigned gap);
    start_i <= 1'b1;
    obj_i   <= o;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_object(o);
    if (gap > 0) begin
      start_i <= 1'b0;
      obj_i   <= rand_object(22);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // stream the batch, then let the pipeline empty
  task automatic run_phase(input bit no_idle);
    int unsigned g;
    for (int j = 0; j < batch.size(); j++) begin
      g = no_idle ? 0 : pick_gap();
      if (j == batch.size() - 1 && g == 0) g = 1;
      send_obj(batch[j], g);
    end
    batch.delete();
    wait_idle();
  endtask

  initial begin
    int unsigned rand_sent;
    int          k;
    int          e;
    int          n;
    logic [ModeW-1:0] md;
    rand_sent = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: zero planes keep every sphere inside, mode zero
    batch.push_back(mk_obj(PosMax, PosMax, PosMax, RadMax, '1, 1'b1));
    batch.push_back(mk_obj(PosMin, PosMin, PosMin, 0, FDraw | FTransl | FStruct | FOccl, 1'b0));
    batch.push_back(mk_obj(0, 0, 0, 5, FDraw | FEffHid, 1'b0));
    batch.push_back(mk_obj(3, -3, 7, 1, FDraw | FShroud | FTransl, 1'b0));
    batch.push_back(mk_obj(0, 0, 0, 0, FHidden, 1'b0));
    batch.push_back(mk_obj(-1, 1, -1, 2, FStruct | FOccl, 1'b1));
    run_phase(1'b0);

    // box of half extent 100, hidden reset and markers on
    for (int p = 0; p < NumPlanes; p++) next_planes[p] = box_plane(p, 100);
    program_regs(ModeW'((1 << ModeRstHidden) | (1 << ModeMarkers)));
    // touching a face exactly still counts as inside
    batch.push_back(mk_obj(116, 0, 0, 16, FDraw | FTransl | FStruct | FOccl, 1'b0));
    batch.push_back(mk_obj(117, 0, 0, 16, FDraw | FTransl | FStruct | FOccl, 1'b0));
    batch.push_back(mk_obj(-116, 0, 0, 16, FDraw | FEffHid, 1'b0));
    batch.push_back(mk_obj(0, -117, 0, 16, 0, 1'b0));
    batch.push_back(mk_obj(0, 0, 50, 3, FDraw | FShroud, 1'b0));
    batch.push_back(mk_obj(0, 0, 117, 16, FForce | FDraw, 1'b0));
    batch.push_back(mk_obj(0, 0, 0, 0, FHidden | FDraw, 1'b1));
    run_phase(1'b0);

    // same box, reflection pass
    program_regs(ModeW'(1 << ModeRefl));
    batch.push_back(mk_obj(0, 0, 0, 4, FDraw, 1'b0));
    batch.push_back(mk_obj(0, 0, 0, 4, FDraw | FMirror, 1'b0));
    batch.push_back(mk_obj(0, 0, 0, 4, FHidden, 1'b0));
    batch.push_back(mk_obj(200, 0, 0, 4, 0, 1'b0));
    batch.push_back(mk_obj(200, 0, 0, 4, FForce | FDraw, 1'b1));
    run_phase(1'b0);

    // register extremes
    next_planes[0] = '1;
    next_planes[1] = mk_plane(NormMin, NormMin, NormMin, DistMax);
    next_planes[2] = mk_plane(NormMax, NormMax, NormMax, DistMin);
    for (int p = 3; p < NumPlanes; p++) next_planes[p] = '0;
    program_regs(ModeW'(1 << ModeMarkers));
    batch.push_back(mk_obj(PosMax, PosMax, PosMax, RadMax, FDraw | FStruct, 1'b0));
    batch.push_back(mk_obj(PosMin, PosMin, PosMin, 0, FDraw | FOccl, 1'b0));
    batch.push_back(mk_obj(PosMin, PosMax, 0, RadMax, FForce, 1'b1));
    run_phase(1'b0);

    // random settings, each with a burst of random objects
    for (int ph = 0; rand_sent < RandItems; ph++) begin
      k = $urandom_range(4, 22);
      e = $urandom_range(1, 1 << k);
      for (int p = 0; p < NumPlanes; p++) next_planes[p] = rand_plane(p, k, e);
      if (ph == 0) md = '1;
      else if (ph == 1) md = '0;
      else md = ModeW'($urandom_range(0, (1 << ModeW) - 1));
      program_regs(md);
      n = $urandom_range(40, 110);
      for (int j = 0; j < n; j++) batch.push_back(rand_object(k));
      rand_sent += n;
      run_phase($urandom_range(0, 3) == 0);
    end

    $display("covered %0d objects under %0d register settings, %0d predicted visible",
             sb.objects, settings, sb.visible);
    $display("%0d result beats checked, %0d mismatches", sb.results, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
